// ===== rtl/nearest_point_table_lookup_assert.svh =====
// Assertion macros used by the nearest point table lookup RTL.
`ifndef NEAREST_POINT_TABLE_LOOKUP_ASSERT_SVH
`define NEAREST_POINT_TABLE_LOOKUP_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is asserted.
`define NPTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check that also holds while reset is asserted.
`define NPTL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define NPTL_ASSERT(lbl, prop, msg)
`define NPTL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/nptl_pkg.sv =====
// Package with shared constants of the nearest point table lookup.
package nptl_pkg;

  // Default table size and coordinate width.
  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned COORD_BITS_DEF  = 16;

  // Operation codes of an input transaction.
  localparam int unsigned OP_BITS = 2;
  localparam logic [OP_BITS-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

endpackage

// ===== rtl/nearest_point_table_lookup.sv =====
// Calibration point-pair table with brute-force nearest point search.
//
// Usage: a transaction is taken when start_i is high and busy_o is low, and
// its single result appears on the result ports for exactly one cycle with
// done_o high; the receiver cannot stall it. Append, clear and the unused op
// code give their result in the cycle after acceptance and keep busy_o low, so a
// new transaction may be started in the very next cycle. A query walks every
// stored pair once through one pipelined distance unit (table RAM read,
// absolute difference, two squares, add and compare), one pair per cycle:
// busy_o stays high until done_o pulses once the last pair has left the
// pipeline. At most TABLE_DEPTH pairs are held, 256 at the default depth. A
// query on an empty table answers in the next cycle with found_o low. Ties go
// to the earliest pair. The table RAM is not cleared; only the fill count is.
module nearest_point_table_lookup #(
  parameter int unsigned TABLE_DEPTH = nptl_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = nptl_pkg::COORD_BITS_DEF,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned DW = 2 * COORD_BITS + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [nptl_pkg::OP_BITS-1:0]  op_i,
  input  logic                          reverse_i,
  input  logic signed [COORD_BITS-1:0]  query_x_i,
  input  logic signed [COORD_BITS-1:0]  query_y_i,
  input  logic signed [COORD_BITS-1:0]  entry_cam_x_i,
  input  logic signed [COORD_BITS-1:0]  entry_cam_y_i,
  input  logic signed [COORD_BITS-1:0]  entry_robot_x_i,
  input  logic signed [COORD_BITS-1:0]  entry_robot_y_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic signed [COORD_BITS-1:0]  out_x_o,
  output logic signed [COORD_BITS-1:0]  out_y_o,
  output logic [DW-1:0]                 best_distance_o,
  output logic                          table_full_o,
  output logic [CW-1:0]                 entry_count_o
);

`include "nearest_point_table_lookup_assert.svh"

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned MW = 4 * COORD_BITS;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  // Sequencer state codes.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic          accept;
  logic          last_addr;

  // Query context.
  logic                rev_q;
  logic signed [C-1:0] qx_q, qy_q;

  // Table RAM: {cam_x, cam_y, robot_x, robot_y} per pair.
  logic [MW-1:0] pair_mem [TABLE_DEPTH];
  logic [MW-1:0] rd_data_q;
  logic          mem_we;

  // Distance pipeline.
  logic                v1_q, v2_q, v3_q;
  logic [C-1:0]        adx_q, ady_q;
  logic [C-1:0]        m2x_q, m2y_q, m3x_q, m3y_q;
  logic [2*C-1:0]      sqx_q, sqy_q;
  logic signed [C-1:0] key_x, key_y, map_x, map_y;
  logic signed [C:0]   dx, dy;
  logic [C:0]          abs_x, abs_y;
  logic [DW-1:0]       sum_sq;

  // Running best match.
  logic          bfound_q;
  logic [DW-1:0] bdist_q;
  logic [C-1:0]  bx_q, by_q;

  // Result registers.
  logic          done_q;
  logic          res_found_q, res_full_q;
  logic [C-1:0]  res_x_q, res_y_q;
  logic [DW-1:0] res_dist_q;

  assign accept    = start_i && !busy_o;
  assign busy_o    = (state_q != ST_IDLE);
  assign last_addr = (CW'(rd_addr_q) == (count_q - CW'(1)));
  assign mem_we    = accept && (op_i == nptl_pkg::OP_APPEND) && (count_q != DEPTH_CNT);

  // Sequencer next state, fill count and scan address.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_addr_d = rd_addr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            nptl_pkg::OP_APPEND: begin
              if (count_q != DEPTH_CNT) begin
                count_d = count_q + CW'(1);
              end
            end
            nptl_pkg::OP_QUERY: begin
              rd_addr_d = '0;
              if (count_q != '0) begin
                state_d = ST_SCAN;
              end
            end
            nptl_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (last_addr) begin
          state_d = ST_DRAIN;
        end else begin
          rd_addr_d = rd_addr_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!(v1_q || v2_q || v3_q)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_addr_q <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      bfound_q  <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_addr_q <= rd_addr_d;
      v1_q      <= (state_q == ST_SCAN);
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      // Start every query with no candidate; the first pair always wins.
      if (accept) begin
        bfound_q <= 1'b0;
      end else if (v3_q) begin
        bfound_q <= 1'b1;
      end
      done_q <= (accept && !((op_i == nptl_pkg::OP_QUERY) && (count_q != '0)))
             || ((state_q == ST_DRAIN) && !(v1_q || v2_q || v3_q));
    end
  end

  // Table RAM write and registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pair_mem[count_q[AW-1:0]] <= {entry_cam_x_i, entry_cam_y_i,
                                    entry_robot_x_i, entry_robot_y_i};
    end
    rd_data_q <= pair_mem[rd_addr_q];
  end

  // Key and mapped point of the pair just read, chosen by direction.
  always_comb begin
    if (rev_q) begin
      key_x = rd_data_q[2*C-1:C];
      key_y = rd_data_q[C-1:0];
      map_x = rd_data_q[4*C-1:3*C];
      map_y = rd_data_q[3*C-1:2*C];
    end else begin
      key_x = rd_data_q[4*C-1:3*C];
      key_y = rd_data_q[3*C-1:2*C];
      map_x = rd_data_q[2*C-1:C];
      map_y = rd_data_q[C-1:0];
    end
    dx     = {qx_q[C-1], qx_q} - {key_x[C-1], key_x};
    dy     = {qy_q[C-1], qy_q} - {key_y[C-1], key_y};
    abs_x  = dx[C] ? (-dx) : dx;
    abs_y  = dy[C] ? (-dy) : dy;
    sum_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
  end

  // Distance pipeline, best-match tracking and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rev_q <= reverse_i;
      qx_q  <= query_x_i;
      qy_q  <= query_y_i;
    end
    // Absolute differences fit in C bits.
    adx_q <= abs_x[C-1:0];
    ady_q <= abs_y[C-1:0];
    m2x_q <= map_x;
    m2y_q <= map_y;
    sqx_q <= (2*C)'(adx_q) * (2*C)'(adx_q);
    sqy_q <= (2*C)'(ady_q) * (2*C)'(ady_q);
    m3x_q <= m2x_q;
    m3y_q <= m2y_q;
    // Strictly nearer pairs replace the best, so the earliest tie stays.
    if (v3_q && (!bfound_q || (sum_sq < bdist_q))) begin
      bdist_q <= sum_sq;
      bx_q    <= m3x_q;
      by_q    <= m3y_q;
    end
    if (accept) begin
      res_found_q <= 1'b0;
      res_x_q     <= '0;
      res_y_q     <= '0;
      res_dist_q  <= '0;
      res_full_q  <= (op_i == nptl_pkg::OP_APPEND) && (count_q == DEPTH_CNT);
    end else if ((state_q == ST_DRAIN) && !(v1_q || v2_q || v3_q)) begin
      res_found_q <= bfound_q;
      res_x_q     <= bx_q;
      res_y_q     <= by_q;
      res_dist_q  <= bdist_q;
      res_full_q  <= 1'b0;
    end
  end

  assign done_o          = done_q;
  assign found_o         = res_found_q;
  assign out_x_o         = res_x_q;
  assign out_y_o         = res_y_q;
  assign best_distance_o = res_dist_q;
  assign table_full_o    = res_full_q;
  assign entry_count_o   = count_q;

  // Checks on the sequencer and the result.
  `NPTL_ASSERT(count_in_range_a, count_q <= DEPTH_CNT, "fill count beyond table depth")
  `NPTL_ASSERT(scan_addr_a, (state_q == ST_SCAN) |-> (CW'(rd_addr_q) < count_q), "scan past count")
  `NPTL_ASSERT(pipe_busy_a, (v2_q || v3_q) |-> (state_q != ST_IDLE), "pipeline work while idle")
  `NPTL_ASSERT(full_count_a, (done_o && table_full_o) |-> (entry_count_o == DEPTH_CNT), "full flag with room")
  `NPTL_ASSERT(found_nonempty_a, (done_o && found_o) |-> (entry_count_o != '0), "match on empty table")

endmodule
